// ===== rtl/swsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsp_pkg: shared types and constants for the shell word splitter
// Result word layout, push group into the result queue, character codes and
// queue sizing.
// ----------------------------------------------------------------------------
package swsp_pkg;

	// default saturation point of the per-line word count
	localparam int WORD_COUNT_MAX_DEF = 255;

	// most results one input byte can produce
	localparam int MAX_RESULTS = 3;

	// result queue sizing (depth is a power of two so pointers wrap freely)
	localparam int FIFO_AW    = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// character codes
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;

	// one result word
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       word_start;
		logic       word_end;
		logic       line_end;
		logic [7:0] words_seen;
		logic       open_quote;
	} result_t;

	// group of results pushed into the queue in one cycle
	typedef struct packed {
		logic [1:0]                   num;
		result_t [MAX_RESULTS-1:0]    ent;
	} push_t;

endpackage

// ===== rtl/swsp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsp_step: tokenizer state and per-byte result logic
// Holds quote, escape and word state plus the word tally, and turns one
// registered input byte into up to three result words.
// ----------------------------------------------------------------------------
module swsp_step #(
	parameter int WORD_COUNT_MAX = swsp_pkg::WORD_COUNT_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      byte_s1,
	input  logic            last_s1,
	output swsp_pkg::push_t push
);

	localparam int         CAP_INT = (WORD_COUNT_MAX > 255) ? 255 : WORD_COUNT_MAX;
	localparam logic [7:0] CAP     = 8'(CAP_INT);

	logic       inside_q, squote_q, dquote_q, esc_q;
	logic [7:0] tally_q;
	logic       inside_d, squote_d, dquote_d, esc_d;
	logic [7:0] tally_d;

	// work out the results and next state for the byte in the input register
	always_comb begin
		logic       iw;
		logic [7:0] tl;
		logic [1:0] nb;
		logic [7:0] ch0, ch1;
		logic [7:0] chx;
		logic       blank;
		logic       close_mk;
		logic [1:0] n;

		iw       = inside_q;
		tl       = tally_q;
		squote_d = squote_q;
		dquote_d = dquote_q;
		esc_d    = esc_q;
		nb       = 2'd0;
		ch0      = byte_s1;
		ch1      = byte_s1;
		chx      = byte_s1;
		close_mk = 1'b0;
		n        = 2'd0;
		push     = '0;
		blank    = (byte_s1 == swsp_pkg::CH_SPACE) ||
			((byte_s1 >= swsp_pkg::CH_TAB) && (byte_s1 <= swsp_pkg::CH_CR));

		// classify the byte against the current quote and escape state
		if (esc_q) begin
			esc_d = 1'b0;
			nb    = 2'd1;
			if (byte_s1 == swsp_pkg::CH_N) begin
				ch0 = swsp_pkg::CH_LF;
			end else if (byte_s1 == swsp_pkg::CH_T) begin
				ch0 = swsp_pkg::CH_TAB;
			end else if ((byte_s1 == swsp_pkg::CH_BSLASH) ||
				(byte_s1 == swsp_pkg::CH_SPACE)) begin
				ch0 = byte_s1;
			end else begin
				ch0 = swsp_pkg::CH_BSLASH;
				nb  = 2'd2;
			end
		end else if (squote_q) begin
			if (byte_s1 == swsp_pkg::CH_SQUOTE) begin
				squote_d = 1'b0;
			end else begin
				nb = 2'd1;
			end
		end else if (dquote_q) begin
			if (byte_s1 == swsp_pkg::CH_DQUOTE) begin
				dquote_d = 1'b0;
			end else begin
				nb = 2'd1;
			end
		end else if (byte_s1 == swsp_pkg::CH_BSLASH) begin
			if (last_s1) begin
				nb = 2'd1;
			end else begin
				esc_d = 1'b1;
			end
		end else if (byte_s1 == swsp_pkg::CH_SQUOTE) begin
			squote_d = 1'b1;
		end else if (byte_s1 == swsp_pkg::CH_DQUOTE) begin
			dquote_d = 1'b1;
		end else if (blank) begin
			close_mk = inside_q && !last_s1;
		end else begin
			nb = 2'd1;
		end

		// emit the word bytes, opening a word on the first one
		for (int k = 0; k < 2; k++) begin
			chx = (k == 0) ? ch0 : ch1;
			if (2'(k) < nb) begin
				if (!iw && (tl < CAP)) begin
					tl = tl + 8'd1;
				end
				push.ent[n].out_char   = chx;
				push.ent[n].char_valid = 1'b1;
				push.ent[n].word_start = !iw;
				push.ent[n].word_end   = 1'b0;
				push.ent[n].line_end   = 1'b0;
				push.ent[n].words_seen = tl;
				push.ent[n].open_quote = 1'b0;
				iw = 1'b1;
				n  = n + 2'd1;
			end
		end

		// close the word on unquoted whitespace
		if (close_mk) begin
			iw                     = 1'b0;
			push.ent[n].out_char   = '0;
			push.ent[n].char_valid = 1'b0;
			push.ent[n].word_start = 1'b0;
			push.ent[n].word_end   = 1'b1;
			push.ent[n].line_end   = 1'b0;
			push.ent[n].words_seen = tl;
			push.ent[n].open_quote = 1'b0;
			n = n + 2'd1;
		end

		// line end marker, then drop all state back to reset
		if (last_s1) begin
			push.ent[n].out_char   = '0;
			push.ent[n].char_valid = 1'b0;
			push.ent[n].word_start = 1'b0;
			push.ent[n].word_end   = iw;
			push.ent[n].line_end   = 1'b1;
			push.ent[n].words_seen = tl;
			push.ent[n].open_quote = squote_d | dquote_d;
			n        = n + 2'd1;
			iw       = 1'b0;
			tl       = '0;
			squote_d = 1'b0;
			dquote_d = 1'b0;
			esc_d    = 1'b0;
		end

		inside_d = iw;
		tally_d  = tl;
		push.num = advance ? n : 2'd0;
	end

	// hold state, advance only when the byte moves into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			squote_q <= 1'b0;
			dquote_q <= 1'b0;
			esc_q    <= 1'b0;
			tally_q  <= '0;
		end else if (advance) begin
			inside_q <= inside_d;
			squote_q <= squote_d;
			dquote_q <= dquote_d;
			esc_q    <= esc_d;
			tally_q  <= tally_d;
		end
	end

endmodule

// ===== rtl/swsp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsp_fifo: result queue
// Takes up to three result words per cycle, hands out one per cycle when popped.
// ----------------------------------------------------------------------------
module swsp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  swsp_pkg::push_t   push,
	input  logic              pop,
	output swsp_pkg::result_t head,
	output logic              not_empty,
	output logic [swsp_pkg::FIFO_AW:0] fill
);

	localparam int AW = swsp_pkg::FIFO_AW;

	swsp_pkg::result_t mem_q [swsp_pkg::FIFO_DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              do_pop;

	assign do_pop    = pop && (cnt_q != '0);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign fill      = cnt_q;

	// write the pushed words at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < swsp_pkg::MAX_RESULTS; i++) begin
			if (2'(i) < push.num) begin
				mem_q[AW'(wr_q + AW'(i))] <= push.ent[i];
			end
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.num);
			rd_q  <= rd_q + AW'(do_pop);
			cnt_q <= cnt_q + (AW+1)'(push.num) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/shell_word_splitter.sv =====
`timescale 1ns / 1ps
// Shell word splitter: streaming command-line tokenizer.
// An accepted byte is held in the input register, then written into the result queue.
// Throughput: one byte per cycle; bytes that give extra results (escapes, line end)
// are absorbed by an 8-entry result queue that drains one word per cycle unless
// result_stall is high; the input stalls while the queue has under three free slots.
// Reset: asynchronous, clears quote/escape/word state, word tally and the queue.
// ----------------------------------------------------------------------------
// shell_word_splitter: top level
// Input register, tokenizer step logic and result queue.
// ----------------------------------------------------------------------------
module shell_word_splitter #(
	parameter int WORD_COUNT_MAX = swsp_pkg::WORD_COUNT_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] in_byte,
	input  logic       line_last,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       word_start,
	output logic       word_end,
	output logic       line_end,
	output logic [7:0] words_seen,
	output logic       open_quote
);

	localparam int AW = swsp_pkg::FIFO_AW;
	localparam logic [AW:0] ROOM_MAX =
		(AW+1)'(swsp_pkg::FIFO_DEPTH - swsp_pkg::MAX_RESULTS);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              room, advance, accept;
	swsp_pkg::push_t   push;
	swsp_pkg::result_t head;
	logic [AW:0]       fill;

	assign room       = (fill <= ROOM_MAX);
	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	// input register: load on accept, drop once moved into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= line_last;
		end
	end

	swsp_step #(
		.WORD_COUNT_MAX(WORD_COUNT_MAX)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.push    (push)
	);

	swsp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (result_valid && !result_stall),
		.head      (head),
		.not_empty (result_valid),
		.fill      (fill)
	);

	assign out_char   = head.out_char;
	assign char_valid = head.char_valid;
	assign word_start = head.word_start;
	assign word_end   = head.word_end;
	assign line_end   = head.line_end;
	assign words_seen = head.words_seen;
	assign open_quote = head.open_quote;

	// queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (AW+1)'(swsp_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// a push only happens with room for the largest group
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> (fill <= ROOM_MAX))
		else $error("push without room");

	// marker words carry no character and start no word
	a_marker_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !char_valid) |-> (out_char == 8'd0 && !word_start))
		else $error("marker carries byte data");

	// byte words never close a word or the line
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && char_valid) |-> (!word_end && !line_end && !open_quote))
		else $error("byte word carries marker flags");

endmodule
